>>> design/tile_slot_cache_lru_core_defines.svh
// Assertion macros used by the tile slot cache top level.
`ifndef TILE_SLOT_CACHE_LRU_CORE_DEFINES_SVH
`define TILE_SLOT_CACHE_LRU_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tscl_pkg.sv
// Shared types and constants of the tile slot cache.
`timescale 1ns / 1ps
`default_nettype none
package tscl_pkg;

  localparam int COORD_W    = 14;
  localparam int NODES_W    = 8;
  localparam int POST_W     = 16;
  localparam int STAMP_W    = 64;
  localparam int OUT_SLOT_W = 4;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_FILL   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] FETCH_READY   = 2'd0;
  localparam logic [1:0] FETCH_NO_GRID = 2'd1;
  localparam logic [1:0] FETCH_PENDING = 2'd2;
  localparam logic [1:0] FETCH_NO_SRC  = 2'd3;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_HIT_HOLE   = 3'd1;
  localparam logic [2:0] ST_MISS       = 3'd2;
  localparam logic [2:0] ST_INSTALLED  = 3'd3;
  localparam logic [2:0] ST_INST_HOLE  = 3'd4;
  localparam logic [2:0] ST_PENDING    = 3'd5;
  localparam logic [2:0] ST_NO_SOURCE  = 3'd6;
  localparam logic [2:0] ST_CLEARED    = 3'd7;

  localparam logic [NODES_W-1:0] MIN_SIDE = 8'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_scan_op;
    logic in_clear_op;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/tile_slot_cache_lru_core.sv
// Top level of the tile slot cache with LRU replacement.
//
// The input channel (in_*) takes one operation per item: lookup, fill after
// fetch, or clear. The result channel (out_*) returns one item per lookup,
// fill or clear; an item with the unused operation code is taken and dropped.
// A lookup or fill reads the slot store one slot per cycle through its single
// read port, checking the key and tracking the oldest use stamp, then commits.
// A clear commits without a scan. No new item is accepted until the current
// item commits. The result is written into the output register at the commit
// and waits there while the receiver stalls; the next item is accepted
// meanwhile, and its commit waits until the register is free.
// Synchronous reset empties every slot, zeroes the use clock and drops any
// pending result.
`timescale 1ns / 1ps
`default_nettype none
module tile_slot_cache_lru_core #(
  parameter int SLOTS      = 12,
  parameter int COORD_BITS = 14
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // op, tile_x, tile_y, fetch_outcome, row_nodes, col_nodes, row_postings,
  // col_postings
  input  wire  [tscl_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // status, slot, side_nodes, postings, one zero pad bit
  output logic [tscl_pkg::OUT_DATA_W-1:0]  out_tdata
);

`include "tile_slot_cache_lru_core_defines.svh"

  tscl_pkg::ctl_cmd_t cmd;
  tscl_pkg::dp_stat_t stat;

  tscl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tscl_dpath #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `TSCL_ASSERT_NOW(a_commit_free, cmd.commit, stat.out_free, "commit while result register busy")
  `TSCL_ASSERT_NOW(a_load_accept, cmd.load, in_tvalid && in_tready, "load without accepted item")
  `TSCL_ASSERT_NEXT(a_scan_blocks, cmd.load && stat.in_scan_op, !in_tready, "item taken in scan")
  `TSCL_ASSERT_NEXT(a_commit_out, cmd.commit, out_tvalid, "commit did not produce a result")

endmodule
`default_nettype wire

>>> design/tscl_ctrl.sv
// Controller state machine sequencing accept, slot scan and commit.
`timescale 1ns / 1ps
`default_nettype none
module tscl_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire tscl_pkg::dp_stat_t  stat,
  output tscl_pkg::ctl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (stat.in_clear_op) begin
            state_nxt = S_DONE;
          end else if (stat.in_scan_op) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/tscl_dpath.sv
// Datapath: slot store, scan compare, use clock, commit and result register.
`timescale 1ns / 1ps
`default_nettype none
module tscl_dpath #(
  parameter int SLOTS      = 12,
  parameter int COORD_BITS = 14
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  [tscl_pkg::IN_DATA_W-1:0]        in_tdata,
  input  wire tscl_pkg::ctl_cmd_t               cmd,
  output tscl_pkg::dp_stat_t                    stat,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [tscl_pkg::OUT_DATA_W-1:0]       out_tdata
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int KEY_W  = (COORD_BITS < tscl_pkg::COORD_W) ? COORD_BITS : tscl_pkg::COORD_W;
  localparam int NW     = tscl_pkg::NODES_W;
  localparam int PW     = tscl_pkg::POST_W;
  localparam int SW     = tscl_pkg::STAMP_W;

  // Input fields.
  logic [1:0]                    f_op;
  logic [tscl_pkg::COORD_W-1:0]  f_x;
  logic [tscl_pkg::COORD_W-1:0]  f_y;
  logic [1:0]                    f_fetch;
  logic [NW-1:0]                 f_rn;
  logic [NW-1:0]                 f_cn;
  logic [PW-1:0]                 f_rp;
  logic [PW-1:0]                 f_cp;

  assign f_op    = in_tdata[1:0];
  assign f_x     = in_tdata[15:2];
  assign f_y     = in_tdata[29:16];
  assign f_fetch = in_tdata[31:30];
  assign f_rn    = in_tdata[39:32];
  assign f_cn    = in_tdata[47:40];
  assign f_rp    = in_tdata[63:48];
  assign f_cp    = in_tdata[79:64];

  // Held item.
  logic [1:0]       op_r;
  logic [KEY_W-1:0] kx_r;
  logic [KEY_W-1:0] ky_r;
  logic [1:0]       fetch_r;
  logic [NW-1:0]    rn_r;
  logic [NW-1:0]    cn_r;
  logic [PW-1:0]    rp_r;
  logic [PW-1:0]    cp_r;

  // Slot store.
  logic [SLOTS-1:0] valid_r;
  logic [SW-1:0]    stamp_mem [SLOTS];
  logic [KEY_W-1:0] kx_mem    [SLOTS];
  logic [KEY_W-1:0] ky_mem    [SLOTS];
  logic             hole_mem  [SLOTS];
  logic [NW-1:0]    side_mem  [SLOTS];
  logic [PW-1:0]    post_mem  [SLOTS];

  logic [SW-1:0]    rd_stamp_r;
  logic [KEY_W-1:0] rd_kx_r;
  logic [KEY_W-1:0] rd_ky_r;
  logic             rd_hole_r;
  logic [NW-1:0]    rd_side_r;
  logic [PW-1:0]    rd_post_r;

  // Scan state.
  logic [SLOT_W-1:0] cnt_r;
  logic [SLOT_W-1:0] idx_r;
  logic              cmp_en_r;
  logic              hit_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic              hit_hole_r;
  logic [NW-1:0]     hit_side_r;
  logic [PW-1:0]     hit_post_r;
  logic [SW-1:0]     min_r;
  logic [SLOT_W-1:0] lru_r;
  logic [SW-1:0]     clock_r;

  // Result register.
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [3:0]        out_slot_r;
  logic [NW-1:0]     out_side_r;
  logic [PW-1:0]     out_post_r;

  // Compare and commit logic.
  logic              cur_valid;
  logic [SW-1:0]     cur_stamp;
  logic              cur_match;
  logic [SW-1:0]     clock_inc;
  logic [SLOT_W-1:0] sel_idx;
  logic              square;
  logic              we;
  logic [SLOT_W-1:0] wa;
  logic              w_hole;
  logic [NW-1:0]     w_side;
  logic [PW-1:0]     w_post;
  logic              set_valid;
  logic              clr_all;
  logic              bump_clock;
  logic [2:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [NW-1:0]     res_side;
  logic [PW-1:0]     res_post;

  assign stat.in_scan_op  = (f_op == tscl_pkg::OP_LOOKUP) || (f_op == tscl_pkg::OP_FILL);
  assign stat.in_clear_op = (f_op == tscl_pkg::OP_CLEAR);
  assign stat.scan_last   = (cnt_r == SLOT_W'(SLOTS - 1));
  assign stat.out_free    = !out_valid_r || out_tready;

  assign cur_valid = valid_r[idx_r];
  assign cur_stamp = cur_valid ? rd_stamp_r : '0;
  assign cur_match = cur_valid && (rd_kx_r == kx_r) && (rd_ky_r == ky_r);
  assign clock_inc = clock_r + SW'(1);
  assign sel_idx   = hit_r ? hit_idx_r : lru_r;
  assign square    = (fetch_r == tscl_pkg::FETCH_READY) && (rn_r >= tscl_pkg::MIN_SIDE) &&
                     (rn_r == cn_r) && (rp_r == cp_r);

  always_comb begin
    we         = 1'b0;
    wa         = sel_idx;
    w_hole     = hit_hole_r;
    w_side     = hit_side_r;
    w_post     = hit_post_r;
    set_valid  = 1'b0;
    clr_all    = 1'b0;
    bump_clock = 1'b0;
    res_status = tscl_pkg::ST_CLEARED;
    res_slot   = '0;
    res_side   = '0;
    res_post   = '0;
    case (op_r)
      tscl_pkg::OP_LOOKUP: begin
        if (hit_r) begin
          we         = 1'b1;
          bump_clock = 1'b1;
          res_slot   = hit_idx_r;
          if (hit_hole_r) begin
            res_status = tscl_pkg::ST_HIT_HOLE;
          end else begin
            res_status = tscl_pkg::ST_HIT;
            res_side   = hit_side_r;
            res_post   = hit_post_r;
          end
        end else begin
          res_status = tscl_pkg::ST_MISS;
          res_slot   = lru_r;
        end
      end
      tscl_pkg::OP_FILL: begin
        res_slot = sel_idx;
        if (fetch_r == tscl_pkg::FETCH_PENDING) begin
          res_status = tscl_pkg::ST_PENDING;
        end else if (fetch_r == tscl_pkg::FETCH_NO_SRC) begin
          res_status = tscl_pkg::ST_NO_SOURCE;
        end else begin
          we         = 1'b1;
          set_valid  = 1'b1;
          bump_clock = 1'b1;
          w_hole     = !square;
          w_side     = square ? rn_r : '0;
          w_post     = square ? cp_r : '0;
          res_status = square ? tscl_pkg::ST_INSTALLED : tscl_pkg::ST_INST_HOLE;
          res_side   = w_side;
          res_post   = w_post;
        end
      end
      tscl_pkg::OP_CLEAR: begin
        clr_all = 1'b1;
      end
      default: begin
        res_status = tscl_pkg::ST_CLEARED;
      end
    endcase
  end

  // Slot store: one write port, one registered read port at the scan index.
  always_ff @(posedge clk) begin
    if (cmd.commit && we) begin
      stamp_mem[wa] <= clock_inc;
      kx_mem[wa]    <= kx_r;
      ky_mem[wa]    <= ky_r;
      hole_mem[wa]  <= w_hole;
      side_mem[wa]  <= w_side;
      post_mem[wa]  <= w_post;
    end
    rd_stamp_r <= stamp_mem[cnt_r];
    rd_kx_r    <= kx_mem[cnt_r];
    rd_ky_r    <= ky_mem[cnt_r];
    rd_hole_r  <= hole_mem[cnt_r];
    rd_side_r  <= side_mem[cnt_r];
    rd_post_r  <= post_mem[cnt_r];
  end

  // Held item and scan results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= f_op;
      kx_r    <= f_x[KEY_W-1:0];
      ky_r    <= f_y[KEY_W-1:0];
      fetch_r <= f_fetch;
      rn_r    <= f_rn;
      cn_r    <= f_cn;
      rp_r    <= f_rp;
      cp_r    <= f_cp;
    end
    if (cmd.step) begin
      idx_r <= cnt_r;
    end
    if (cmp_en_r) begin
      if (idx_r == '0 || cur_stamp < min_r) begin
        min_r <= cur_stamp;
        lru_r <= idx_r;
      end
      if (cur_match && !hit_r) begin
        hit_idx_r  <= idx_r;
        hit_hole_r <= rd_hole_r;
        hit_side_r <= rd_side_r;
        hit_post_r <= rd_post_r;
      end
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= 4'(res_slot);
      out_side_r   <= res_side;
      out_post_r   <= res_post;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      clock_r     <= '0;
      cnt_r       <= '0;
      cmp_en_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.step;
      if (cmd.load) begin
        cnt_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.step && !stat.scan_last) begin
        cnt_r <= cnt_r + SLOT_W'(1);
      end
      if (cmp_en_r && cur_match) begin
        hit_r <= 1'b1;
      end
      if (cmd.commit) begin
        if (clr_all) begin
          valid_r <= '0;
          clock_r <= '0;
        end else begin
          if (set_valid) begin
            valid_r[wa] <= 1'b1;
          end
          if (bump_clock) begin
            clock_r <= clock_inc;
          end
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_post_r, out_side_r, out_slot_r, out_status_r};

endmodule
`default_nettype wire

>>> verif/tile_slot_cache_lru_core_tb.sv
// Self-checking testbench of the tile slot cache with LRU replacement.
`timescale 1ns / 1ps
module tile_slot_cache_lru_core_tb;

  localparam int SLOTS      = 12;
  localparam int POOL_KEYS  = 20;
  localparam int STALL_MAX  = 2000;
  localparam int MAX_SHOWN  = 10;

  // Packed so that op lands in the lowest bits of in_tdata.
  typedef struct packed {
    logic [tscl_pkg::POST_W-1:0]  col_postings;
    logic [tscl_pkg::POST_W-1:0]  row_postings;
    logic [tscl_pkg::NODES_W-1:0] col_nodes;
    logic [tscl_pkg::NODES_W-1:0] row_nodes;
    logic [1:0]                   outcome;
    logic [tscl_pkg::COORD_W-1:0] tile_y;
    logic [tscl_pkg::COORD_W-1:0] tile_x;
    logic [1:0]                   op;
  } tile_req_t;

  typedef struct packed {
    logic                            pad;
    logic [tscl_pkg::POST_W-1:0]     postings;
    logic [tscl_pkg::NODES_W-1:0]    side_nodes;
    logic [tscl_pkg::OUT_SLOT_W-1:0] slot;
    logic [2:0]                      status;
  } tile_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tscl_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tscl_pkg::OUT_DATA_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;

  tile_reply_t owed_replies[$];

  logic                          shadow_valid [SLOTS];
  logic                          shadow_hole  [SLOTS];
  logic [tscl_pkg::COORD_W-1:0]  shadow_x     [SLOTS];
  logic [tscl_pkg::COORD_W-1:0]  shadow_y     [SLOTS];
  logic [tscl_pkg::STAMP_W-1:0]  shadow_stamp [SLOTS];
  logic [tscl_pkg::NODES_W-1:0]  shadow_side  [SLOTS];
  logic [tscl_pkg::POST_W-1:0]   shadow_post  [SLOTS];
  logic [tscl_pkg::STAMP_W-1:0]  shadow_use_clock;

  logic [tscl_pkg::COORD_W-1:0] pool_x [POOL_KEYS];
  logic [tscl_pkg::COORD_W-1:0] pool_y [POOL_KEYS];

  tile_slot_cache_lru_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_hole[i]  = 1'b0;
      shadow_x[i]     = '0;
      shadow_y[i]     = '0;
      shadow_stamp[i] = '0;
      shadow_side[i]  = '0;
      shadow_post[i]  = '0;
    end
    shadow_use_clock = '0;
  endfunction

  function automatic int find_resident(input logic [tscl_pkg::COORD_W-1:0] kx,
                                       input logic [tscl_pkg::COORD_W-1:0] ky);
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_x[i] == kx && shadow_y[i] == ky) return i;
    end
    return -1;
  endfunction

  // Applies one item to the shadow cache; returns 0 when no reply is due.
  function automatic bit predict_reply(input tile_req_t r, output tile_reply_t rep);
    int hit;
    int victim;
    int s;
    bit square;
    rep = '0;
    if (r.op == tscl_pkg::OP_CLEAR) begin
      clear_shadow();
      rep.status = tscl_pkg::ST_CLEARED;
      return 1'b1;
    end
    if (r.op != tscl_pkg::OP_LOOKUP && r.op != tscl_pkg::OP_FILL) return 1'b0;
    hit = find_resident(r.tile_x, r.tile_y);
    victim = 0;
    for (int i = 1; i < SLOTS; i++) begin
      if (shadow_stamp[i] < shadow_stamp[victim]) victim = i;
    end
    if (r.op == tscl_pkg::OP_LOOKUP) begin
      if (hit < 0) begin
        rep.status = tscl_pkg::ST_MISS;
        rep.slot = 4'(victim);
        return 1'b1;
      end
      shadow_use_clock = shadow_use_clock + 64'd1;
      shadow_stamp[hit] = shadow_use_clock;
      rep.slot = 4'(hit);
      if (shadow_hole[hit]) begin
        rep.status = tscl_pkg::ST_HIT_HOLE;
      end else begin
        rep.status = tscl_pkg::ST_HIT;
        rep.side_nodes = shadow_side[hit];
        rep.postings = shadow_post[hit];
      end
      return 1'b1;
    end
    s = (hit >= 0) ? hit : victim;
    rep.slot = 4'(s);
    if (r.outcome == tscl_pkg::FETCH_PENDING) begin
      rep.status = tscl_pkg::ST_PENDING;
      return 1'b1;
    end
    if (r.outcome == tscl_pkg::FETCH_NO_SRC) begin
      rep.status = tscl_pkg::ST_NO_SOURCE;
      return 1'b1;
    end
    square = (r.outcome == tscl_pkg::FETCH_READY) && (r.row_nodes >= tscl_pkg::MIN_SIDE) &&
             (r.row_nodes == r.col_nodes) && (r.row_postings == r.col_postings);
    shadow_use_clock = shadow_use_clock + 64'd1;
    shadow_valid[s] = 1'b1;
    shadow_x[s]     = r.tile_x;
    shadow_y[s]     = r.tile_y;
    shadow_stamp[s] = shadow_use_clock;
    shadow_hole[s]  = !square;
    shadow_side[s]  = square ? r.row_nodes : '0;
    shadow_post[s]  = square ? r.col_postings : '0;
    rep.status     = square ? tscl_pkg::ST_INSTALLED : tscl_pkg::ST_INST_HOLE;
    rep.side_nodes = shadow_side[s];
    rep.postings   = shadow_post[s];
    return 1'b1;
  endfunction

  function automatic tile_req_t make_item(input logic [1:0] op,
                                          input logic [tscl_pkg::COORD_W-1:0] kx,
                                          input logic [tscl_pkg::COORD_W-1:0] ky,
                                          input logic [1:0] outcome,
                                          input logic [tscl_pkg::NODES_W-1:0] rn,
                                          input logic [tscl_pkg::NODES_W-1:0] cn,
                                          input logic [tscl_pkg::POST_W-1:0] rp,
                                          input logic [tscl_pkg::POST_W-1:0] cp);
    tile_req_t r;
    r.op = op;
    r.tile_x = kx;
    r.tile_y = ky;
    r.outcome = outcome;
    r.row_nodes = rn;
    r.col_nodes = cn;
    r.row_postings = rp;
    r.col_postings = cp;
    return r;
  endfunction

  task automatic send_item(input tile_req_t r);
    tile_reply_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (predict_reply(r, rep)) owed_replies.push_back(rep);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string what, input tile_reply_t want,
                              input tile_reply_t got);
    fail_count++;
    if (fail_count <= MAX_SHOWN) begin
      $display("%0t: %s: expected status %0d slot %0d side %0d postings %0d,",
               $realtime, what, want.status, want.slot, want.side_nodes, want.postings,
               " got status %0d slot %0d side %0d postings %0d",
               got.status, got.slot, got.side_nodes, got.postings);
    end
  endtask

  always @(posedge clk) begin
    tile_reply_t got;
    tile_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (owed_replies.size() == 0) begin
        note_failure("result with nothing outstanding", '0, got);
      end else begin
        want = owed_replies.pop_front();
        if (got.status != want.status || got.slot != want.slot ||
            got.side_nodes != want.side_nodes || got.postings != want.postings) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic test_directed_ops();
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'd0, 14'd0, tscl_pkg::FETCH_READY, 8'd0, 8'd0,
                        16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd0, 14'd0, tscl_pkg::FETCH_READY, 8'd2, 8'd2,
                        16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'd0, 14'd0, tscl_pkg::FETCH_READY, 8'd0, 8'd0,
                        16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_FILL, 14'h3FFF, 14'h3FFF, tscl_pkg::FETCH_READY,
                        8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'h3FFF, 14'h3FFF, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_FILL, 14'h3FFF, 14'd0, tscl_pkg::FETCH_READY,
                        8'd1, 8'd1, 16'd5, 16'd5));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd0, 14'h3FFF, tscl_pkg::FETCH_READY,
                        8'd3, 8'd4, 16'd5, 16'd5));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd1, 14'd1, tscl_pkg::FETCH_READY,
                        8'd5, 8'd5, 16'd1, 16'd2));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd2, 14'd2, tscl_pkg::FETCH_NO_GRID,
                        8'd9, 8'd9, 16'd7, 16'd7));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'h3FFF, 14'd0, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd3, 14'd3, tscl_pkg::FETCH_PENDING,
                        8'd4, 8'd4, 16'd8, 16'd8));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd3, 14'd3, tscl_pkg::FETCH_NO_SRC,
                        8'd4, 8'd4, 16'd8, 16'd8));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'd3, 14'd3, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_FILL, 14'd0, 14'd0, tscl_pkg::FETCH_READY,
                        8'd7, 8'd7, 16'd100, 16'd100));
    send_item(make_item(tscl_pkg::OP_FILL, 14'h3FFF, 14'h3FFF, tscl_pkg::FETCH_NO_GRID,
                        8'd6, 8'd6, 16'd9, 16'd9));
    send_item(make_item(2'd3, 14'h1555, 14'h2AAA, tscl_pkg::FETCH_READY,
                        8'd2, 8'd2, 16'd1, 16'd1));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'd0, 14'd0, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'h3FFF, 14'h3FFF, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_CLEAR, 14'd0, 14'd0, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'd0, 14'd0, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    send_item(make_item(2'd3, 14'h3FFF, 14'h3FFF, tscl_pkg::FETCH_NO_SRC,
                        8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(tscl_pkg::OP_LOOKUP, 14'h3FFF, 14'h3FFF, tscl_pkg::FETCH_READY,
                        8'd0, 8'd0, 16'd0, 16'd0));
    wait_drained();
  endtask

  // Most items are lookup-then-fill pairs over a key pool larger than the
  // cache, so hits, hole hits and evictions all recur.
  task automatic test_random_traffic(input int n_items, input int sender_pct,
                                     input int receiver_pct);
    int sent;
    int roll;
    int k;
    logic [tscl_pkg::COORD_W-1:0] kx;
    logic [tscl_pkg::COORD_W-1:0] ky;
    logic [1:0] outcome;
    logic [tscl_pkg::NODES_W-1:0] rn;
    logic [tscl_pkg::POST_W-1:0] rp;
    tile_req_t r;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_x[i] = 14'($urandom_range(16383));
      pool_y[i] = 14'($urandom_range(16383));
    end
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_item(make_item(tscl_pkg::OP_CLEAR, 14'($urandom), 14'($urandom), 2'($urandom),
                            8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)));
        sent++;
      end else if (roll < 4) begin
        r = {$urandom, $urandom, 16'($urandom)};
        r.op = 2'd3;
        send_item(r);
      end else if (roll < 14) begin
        r = {$urandom, $urandom, 16'($urandom)};
        r.op = $urandom_range(1) ? tscl_pkg::OP_FILL : tscl_pkg::OP_LOOKUP;
        send_item(r);
        sent++;
      end else begin
        if ($urandom_range(9) == 0) begin
          kx = 14'($urandom_range(16383));
          ky = 14'($urandom_range(16383));
        end else begin
          k = $urandom_range(POOL_KEYS - 1);
          kx = pool_x[k];
          ky = pool_y[k];
        end
        send_item(make_item(tscl_pkg::OP_LOOKUP, kx, ky, 2'($urandom), 8'($urandom),
                            8'($urandom), 16'($urandom), 16'($urandom)));
        sent++;
        if ((find_resident(kx, ky) < 0) ? ($urandom_range(99) < 85)
                                        : ($urandom_range(99) < 15)) begin
          roll = $urandom_range(99);
          outcome = (roll < 55) ? tscl_pkg::FETCH_READY :
                    (roll < 70) ? tscl_pkg::FETCH_NO_GRID :
                    (roll < 85) ? tscl_pkg::FETCH_PENDING : tscl_pkg::FETCH_NO_SRC;
          rn = 8'($urandom_range(255, 2));
          rp = 16'($urandom);
          r = make_item(tscl_pkg::OP_FILL, kx, ky, outcome, rn, rn, rp, rp);
          if ($urandom_range(3) == 0) begin
            roll = $urandom_range(2);
            if (roll == 0) begin
              r.row_nodes = 8'($urandom_range(1));
              r.col_nodes = r.row_nodes;
            end else if (roll == 1) begin
              r.col_nodes = rn ^ (8'd1 << $urandom_range(7));
            end else begin
              r.col_postings = rp ^ (16'd1 << $urandom_range(15));
            end
          end
          send_item(r);
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    clear_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_random_traffic(400, 31, 59);
    test_random_traffic(400, 59, 31);
    test_random_traffic(380, 0, 0);
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/tscl_pkg.sv
design/tscl_ctrl.sv
design/tscl_dpath.sv
design/tile_slot_cache_lru_core.sv
verif/tile_slot_cache_lru_core_tb.sv
